// ===== hdl/ova_pkg.sv =====
// Package for the orientation vector advect core.
// Fixed-point widths, stage counts and register indexes; no dependencies.
`default_nettype none
package ova_pkg;

	localparam int FRAC_BITS  = 30;        // Q2.30 vectors
	localparam int STEP_SHIFT = 18;        // gradient * step scaled down to Q.30
	localparam int VEC_W      = 32;        // one input/output component
	localparam int N_GRAD     = 9;         // 3x3 gradient entries
	localparam int A_W        = 64 - STEP_SHIFT; // scaled gradient
	localparam int PP_W       = A_W + 1;   // one n_i * A_ij term
	localparam int P_W        = PP_W + 2;  // p_j, sum of three terms
	localparam int QQ_W       = P_W + 1;
	localparam int Q_W        = QQ_W + 2;  // n.A.n
	localparam int T_W        = Q_W + 1;
	localparam int V_W        = T_W + 1;   // advected vector component
	localparam int LEAD_W     = 6;         // bit index into V_W
	localparam int W_W        = FRAC_BITS + 1; // normalized magnitude
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int NUM_W      = W_W + FRAC_BITS + 1;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = ROOT_W;
	localparam int FRONT_STAGES = 16;

	localparam logic [SUM_W-1:0]  LEN_LIMIT = 64'h0400_0000_0000_0000; // 0.5^2 in Q4.60
	localparam logic [ROOT_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STEP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 1'd1;

	localparam int IN_W  = VEC_W * (3 + N_GRAD);
	localparam int OUT_W = VEC_W * 3;

	typedef logic signed [VEC_W-1:0] comp_t;

endpackage
`default_nettype wire

// ===== hdl/orientation_vector_advect_core.sv =====
// Top level of the orientation vector advect core.
// Uses ova_pkg, ova_mulq, ova_isqrt, ova_div and ova_delay.
//
// Advects one particle's Q2.30 orientation vector n by a raw 3x3 velocity
// gradient L over one time step (step_length, scaled by 2^-48) and returns
// the unit result. Vectors with |n| <= 0.5 return zero; with first_step set
// the input is only normalized. The core takes one beat per clock while
// s_tready is high and holds many particles in flight. The pipeline is the
// 16-stage front end (advection with three chained two-stage multiplies,
// then normalization), the 32-stage square root and the 32-stage divider.
// A stalled output parks one result in a skid register, so s_tready only
// drops when two results wait.
// Write configuration only while the core is empty.
`default_nettype none
module orientation_vector_advect_core import ova_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// fields low to high: dir_x, dir_y, dir_z, grad_xx, grad_xy, grad_xz,
	// grad_yx, grad_yy, grad_yz, grad_zx, grad_zy, grad_zz
	input  wire logic [IN_W-1:0]       s_tdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// fields low to high: new_x, new_y, new_z
	output logic [OUT_W-1:0]           m_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic                  first_q;
	logic [CFG_DATA_W-1:0] step_q;
	logic                  en;
	logic [FRONT_STAGES-1:0] vld_q;   // bit k: stage k+1 holds a beat

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			step_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FIRST_STEP:  first_q <= cfg_data[0];
				CFG_STEP_LENGTH: step_q  <= cfg_data;
			endcase
		end
	end

	// front-end valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[FRONT_STAGES-2:0], s_tvalid};
	end

	// ---- advection front end ----
	comp_t                   n_s1 [3];
	comp_t                   g_s1 [N_GRAD];
	logic signed [63:0]      araw_s2 [N_GRAD];
	logic [SUM_W-1:0]        sq_s2 [3];
	comp_t                   n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3];
	comp_t                   n_s8 [3], n_s9 [3], n_s10 [3];
	logic                    big_s3, big_s4, big_s5, big_s6, big_s7, big_s8, big_s9, big_s10;
	logic signed [A_W-1:0]   a_c [N_GRAD];
	logic signed [PP_W-1:0]  pp [N_GRAD];
	logic signed [P_W-1:0]   p_s5 [3], p_s6 [3], p_s7 [3], p_s8 [3], p_s9 [3], p_s10 [3];
	logic signed [QQ_W-1:0]  qq [3];
	logic signed [Q_W-1:0]   q_s8;
	logic signed [T_W-1:0]   t [3];
	logic signed [V_W-1:0]   vec_s11 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) n_s1[i] <= s_tdata[VEC_W*i +: VEC_W];
			for (int k = 0; k < N_GRAD; k++) g_s1[k] <= s_tdata[VEC_W*(3+k) +: VEC_W];
			// s2: scale gradient, square components
			for (int k = 0; k < N_GRAD; k++) araw_s2[k] <= g_s1[k] * $signed({1'b0, step_q});
			for (int i = 0; i < 3; i++) sq_s2[i] <= n_s1[i] * n_s1[i];
			n_s2 <= n_s1;
			// s3: length test
			big_s3 <= (sq_s2[0] + sq_s2[1] + sq_s2[2]) > LEN_LIMIT;
			n_s3 <= n_s2;
			n_s4 <= n_s3;  big_s4 <= big_s3;
			// s5: p_j = sum_i n_i A_ij
			for (int j = 0; j < 3; j++)
				p_s5[j] <= P_W'(pp[j]) + P_W'(pp[3+j]) + P_W'(pp[6+j]);
			n_s5 <= n_s4;  big_s5 <= big_s4;
			n_s6 <= n_s5;  big_s6 <= big_s5;  p_s6 <= p_s5;
			n_s7 <= n_s6;  big_s7 <= big_s6;  p_s7 <= p_s6;
			// s8: q = n.A.n
			q_s8 <= Q_W'(qq[0]) + Q_W'(qq[1]) + Q_W'(qq[2]);
			n_s8 <= n_s7;  big_s8 <= big_s7;  p_s8 <= p_s7;
			n_s9 <= n_s8;  big_s9 <= big_s8;  p_s9 <= p_s8;
			n_s10 <= n_s9; big_s10 <= big_s9; p_s10 <= p_s9;
			// s11: pick the vector to normalize
			for (int j = 0; j < 3; j++) begin
				if (!big_s10)    vec_s11[j] <= '0;
				else if (first_q) vec_s11[j] <= V_W'(n_s10[j]);
				else             vec_s11[j] <= V_W'(n_s10[j]) + V_W'(t[j]) - V_W'(p_s10[j]);
			end
		end
	end

	for (genvar k = 0; k < N_GRAD; k++) begin : g_mul_a
		assign a_c[k] = araw_s2[k][63:STEP_SHIFT];
		ova_mulq #(.AW(A_W)) u_mul (.clk(clk), .en(en), .a(a_c[k]), .b(n_s2[k/3]), .y(pp[k]));
	end
	for (genvar j = 0; j < 3; j++) begin : g_mul_pq
		ova_mulq #(.AW(P_W)) u_mul_p (.clk(clk), .en(en), .a(p_s5[j]), .b(n_s5[j]), .y(qq[j]));
		ova_mulq #(.AW(Q_W)) u_mul_q (.clk(clk), .en(en), .a(q_s8), .b(n_s8[j]), .y(t[j]));
	end

	// ---- normalization front ----
	logic [V_W-1:0]    mag_s12 [3], mag_s13 [3];
	logic [2:0]        neg_s12, neg_s13, neg_s14, neg_s15, neg_s16;
	logic [V_W-1:0]    orv_c;
	logic [LEAD_W-1:0] lead_c, lead_s13;
	logic              nz_s13, nz_s14, nz_s15, nz_s16;
	logic [W_W-1:0]    w_s14 [3], w_s15 [3], w_s16 [3];
	logic [V_W-1:0]    sh_c [3];
	logic [2*W_W-1:0]  wsq_s15 [3];
	logic [SUM_W-1:0]  ssum_s16;

	assign orv_c = mag_s12[0] | mag_s12[1] | mag_s12[2];

	always_comb begin
		lead_c = '0;
		for (int b = 0; b < V_W; b++) if (orv_c[b]) lead_c = LEAD_W'(b);
	end

	// bring the largest magnitude into [2^30, 2^31)
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (lead_s13 > LEAD_W'(FRAC_BITS))
				sh_c[j] = mag_s13[j] >> (lead_s13 - LEAD_W'(FRAC_BITS));
			else
				sh_c[j] = mag_s13[j] << (LEAD_W'(FRAC_BITS) - lead_s13);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				neg_s12[j] <= vec_s11[j][V_W-1];
				mag_s12[j] <= vec_s11[j][V_W-1] ? V_W'(-vec_s11[j]) : V_W'(vec_s11[j]);
			end
			lead_s13 <= lead_c;  nz_s13 <= |orv_c;  mag_s13 <= mag_s12;  neg_s13 <= neg_s12;
			for (int j = 0; j < 3; j++) w_s14[j] <= sh_c[j][W_W-1:0];
			nz_s14 <= nz_s13;  neg_s14 <= neg_s13;
			for (int j = 0; j < 3; j++) wsq_s15[j] <= w_s14[j] * w_s14[j];
			w_s15 <= w_s14;  nz_s15 <= nz_s14;  neg_s15 <= neg_s14;
			ssum_s16 <= SUM_W'(wsq_s15[0]) + SUM_W'(wsq_s15[1]) + SUM_W'(wsq_s15[2]);
			w_s16 <= w_s15;  nz_s16 <= nz_s15;  neg_s16 <= neg_s15;
		end
	end

	// ---- square root, then three divides ----
	localparam int SIDE1_W = 3*W_W + 4;
	localparam int SIDE2_W = 4;
	logic [ROOT_W-1:0]  root;
	logic               sv1, sv2;
	logic [SIDE1_W-1:0] side1;
	logic [SIDE2_W-1:0] side2;
	logic [ROOT_W-1:0]  quo [3];
	logic [NUM_W-1:0]   num_c [3];

	ova_isqrt u_isqrt (.clk(clk), .en(en), .s(ssum_s16), .r(root));

	ova_delay #(.W(SIDE1_W), .D(SQRT_STAGES)) u_dly_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(vld_q[FRONT_STAGES-1]),
		.din({w_s16[2], w_s16[1], w_s16[0], nz_s16, neg_s16}), .vout(sv1), .dout(side1));

	for (genvar j = 0; j < 3; j++) begin : g_div
		assign num_c[j] = NUM_W'({side1[4+W_W*j +: W_W], FRAC_BITS'(0)}) + NUM_W'(root >> 1);
		ova_div u_div (.clk(clk), .en(en), .num(num_c[j]), .den(root), .quo(quo[j]));
	end

	ova_delay #(.W(SIDE2_W), .D(DIV_STAGES)) u_dly_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(sv1), .din(side1[SIDE2_W-1:0]),
		.vout(sv2), .dout(side2));

	// clamp, restore sign; zero vector gives zero
	logic [OUT_W-1:0]  res_c;
	logic [ROOT_W-1:0] qc_c [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qc_c[j] = (quo[j] > SAT_MAX) ? SAT_MAX : quo[j];
			if (!side2[3])     res_c[VEC_W*j +: VEC_W] = '0;
			else if (side2[j]) res_c[VEC_W*j +: VEC_W] = -qc_c[j];
			else               res_c[VEC_W*j +: VEC_W] = qc_c[j];
		end
	end

	// ---- output register plus skid ----
	logic             out_v_q, skid_v_q;
	logic [OUT_W-1:0] out_d_q, skid_d_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) skid_v_q <= 1'b0;
		end else if (sv2) begin
			if (!out_v_q || m_tready) out_v_q <= 1'b1;
			else                     skid_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) out_d_q <= skid_d_q;
		end else if (sv2) begin
			if (!out_v_q || m_tready) out_d_q  <= res_c;
			else                     skid_d_q <= res_c;
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
endmodule
`default_nettype wire

// ===== hdl/ova_delay.sv =====
// Delay line with a valid bit, advancing on the shared pipeline enable.
// No package dependencies; width and depth come from the caller.
`default_nettype none
module ova_delay #(
	parameter int W = 8,
	parameter int D = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vin,
	input  wire logic [W-1:0] din,
	output logic              vout,
	output logic [W-1:0]      dout
);
	logic [W-1:0] dat_q [D];
	logic [D-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q[0] <= din;
			for (int k = 1; k < D; k++) dat_q[k] <= dat_q[k-1];
		end
	end

	assign vout = vld_q[D-1];
	assign dout = dat_q[D-1];
endmodule
`default_nettype wire

// ===== hdl/ova_mulq.sv =====
// Two-stage floor(a * b / 2^30) for a wide signed a and 32-bit signed b.
// Split into two partial products of at most 32x32; depends on ova_pkg.
`default_nettype none
module ova_mulq import ova_pkg::*; #(
	parameter int AW = 46  // 32 < AW < 64
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [VEC_W-1:0] b,
	output logic signed [AW:0]        y
);
	localparam int LO_W = VEC_W - 1;
	localparam int HI_W = AW - LO_W;
	localparam int PW   = AW + VEC_W;

	logic signed [2*VEC_W-1:0]      lo_s1;
	logic signed [HI_W+VEC_W-1:0]   hi_s1;
	logic signed [PW-1:0]           full_c;
	logic signed [AW:0]             y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= $signed({1'b0, a[LO_W-1:0]}) * b;
			hi_s1 <= $signed(a[AW-1:LO_W]) * b;
		end
	end

	assign full_c = (PW'(hi_s1) <<< LO_W) + PW'(lo_s1);

	always_ff @(posedge clk) begin
		if (en) y_s2 <= full_c[FRAC_BITS+AW:FRAC_BITS];  // floor by truncation
	end

	assign y = y_s2;
endmodule
`default_nettype wire

// ===== hdl/ova_isqrt.sv =====
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on ova_pkg for widths and stage count.
`default_nettype none
module ova_isqrt import ova_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SUM_W-1:0]  s,
	output logic [ROOT_W-1:0]      r
);
	logic [SUM_W-1:0] rem_s  [SQRT_STAGES];
	logic [SUM_W-1:0] root_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2*k);
		logic [SUM_W-1:0] s_in, r_in, trial;
		if (k == 0) begin : g_first
			assign s_in = s;
			assign r_in = '0;
		end else begin : g_next
			assign s_in = rem_s[k-1];
			assign r_in = root_s[k-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (s_in >= trial) begin
					rem_s[k]  <= s_in - trial;
					root_s[k] <= (r_in >> 1) + BIT;
				end else begin
					rem_s[k]  <= s_in;
					root_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign r = root_s[SQRT_STAGES-1][ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/ova_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit 32 bits; depends on ova_pkg.
`default_nettype none
module ova_div import ova_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [ROOT_W-1:0] den,
	output logic [ROOT_W-1:0]      quo
);
	logic [SUM_W-1:0]  rem_s [DIV_STAGES];
	logic [ROOT_W-1:0] den_s [DIV_STAGES];
	logic [ROOT_W-1:0] quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
		localparam int SH = DIV_STAGES - 1 - k;
		logic [SUM_W-1:0]  rem_in, dsh;
		logic [ROOT_W-1:0] den_in, quo_in;
		if (k == 0) begin : g_first
			assign rem_in = SUM_W'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end
		assign dsh = SUM_W'(den_in) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				if (rem_in >= dsh) begin
					rem_s[k] <= rem_in - dsh;
					quo_s[k] <= quo_in | (ROOT_W'(1) << SH);
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];
endmodule
`default_nettype wire

// ===== hdl/ova_checker.sv =====
// Port-level checks for orientation_vector_advect_core, bound to the top.
// Depends on ova_pkg and the top level.
`default_nettype none
module ova_checker import ova_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);
	localparam logic signed [VEC_W-1:0] UNIT = 32'sd1073741824;
	logic in_range;

	always_comb begin
		in_range = 1'b1;
		for (int j = 0; j < 3; j++)
			if ($signed(m_tdata[VEC_W*j +: VEC_W]) > UNIT ||
			    $signed(m_tdata[VEC_W*j +: VEC_W]) < -UNIT)
				in_range = 1'b0;
	end

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed under stall");

	// input side only blocks while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input blocked with empty output");

	// skid fills only from a stalled output
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input blocked without output stall");

	// unit vector components stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_range)
		else $error("result component above unit length");
endmodule

bind orientation_vector_advect_core ova_checker u_ova_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire

// ===== bench/orientation_vector_advect_core_test.sv =====
// Testbench for orientation_vector_advect_core: directed and random beats, random
// idling on both streams, and several register settings. Uses ova_pkg.
`timescale 1ns / 100ps
module orientation_vector_advect_core_test;
	import ova_pkg::*;

	logic clk, arst_n;
	logic [IN_W-1:0] s_tdata;
	logic s_tvalid, s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tvalid, m_tready;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	orientation_vector_advect_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor copy of the registers
	bit         only_normalize;
	bit [31:0]  dt_raw;

	logic [OUT_W-1:0] pending_dirs[$];
	int  errors;
	bit  no_idle;          // when set, neither side inserts gaps
	bit  sender_hold;      // declared but never read

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint mulq(longint a, longint b);
		longint lo, hi;
		lo = a & ((64'sd1 << FRAC_BITS) - 1);
		hi = a >>> FRAC_BITS;
		return hi * b + ((lo * b) >>> FRAC_BITS);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// scale to a unit vector; zero in gives zero out
	function automatic logic [OUT_W-1:0] unit_vec(longint v[3]);
		longint unsigned w[3], m, sum, r, q;
		logic [OUT_W-1:0] o;
		m = 0;
		sum = 0;
		o = '0;
		for (int j = 0; j < 3; j++) begin
			w[j] = v[j] < 0 ? -v[j] : v[j];
			if (w[j] > m) m = w[j];
		end
		if (m == 0) return o;
		while (m >= (64'd1 << 31)) begin
			m >>= 1;
			for (int j = 0; j < 3; j++) w[j] >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			m <<= 1;
			for (int j = 0; j < 3; j++) w[j] <<= 1;
		end
		for (int j = 0; j < 3; j++) sum += w[j] * w[j];
		r = root_floor(sum);
		for (int j = 0; j < 3; j++) begin
			q = ((w[j] << FRAC_BITS) + (r >> 1)) / r;
			if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
			o[j*VEC_W +: VEC_W] = v[j] < 0 ? -q[31:0] : q[31:0];
		end
		return o;
	endfunction

	function automatic logic [OUT_W-1:0] advect_dir(logic [IN_W-1:0] beat);
		longint n[3], a[3][3], p[3], v[3], q;
		longint unsigned len2;
		comp_t c;
		len2 = 0;
		q = 0;
		for (int i = 0; i < 3; i++) begin
			c = beat[i*VEC_W +: VEC_W];
			n[i] = c;
			len2 += n[i] * n[i];
		end
		if (len2 <= LEN_LIMIT) return '0;
		if (only_normalize) return unit_vec(n);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				c = beat[(3 + 3*i + j)*VEC_W +: VEC_W];
				a[i][j] = (longint'(c) * longint'({32'd0, dt_raw})) >>> STEP_SHIFT;
			end
		for (int j = 0; j < 3; j++) begin
			p[j] = 0;
			for (int i = 0; i < 3; i++) p[j] += mulq(a[i][j], n[i]);
		end
		for (int j = 0; j < 3; j++) q += mulq(p[j], n[j]);
		for (int j = 0; j < 3; j++) v[j] = n[j] + mulq(q, n[j]) - p[j];
		return unit_vec(v);
	endfunction

	// ---------------------------------------------------------------- result side
	int stall_left;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dirs.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, m_tdata);
				errors++;
			end else begin
				logic [OUT_W-1:0] exp_v;
				exp_v = pending_dirs.pop_front();
				for (int j = 0; j < 3; j++)
					if (exp_v[j*VEC_W +: VEC_W] !== m_tdata[j*VEC_W +: VEC_W]) begin
						$display("%0t: comp %0d expected %h actual %h", $time, j,
							exp_v[j*VEC_W +: VEC_W], m_tdata[j*VEC_W +: VEC_W]);
						errors++;
					end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 16);
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- stimulus helpers
	task automatic send_beat(logic [IN_W-1:0] beat);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_dirs = {pending_dirs, advect_dir(beat)};
	endtask

	// drain and let the pipe empty; write_reg then writes one register
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_dirs.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FIRST_STEP) only_normalize = val[0];
		else dt_raw = val;
	endtask

	function automatic logic [IN_W-1:0] pack(comp_t d[3], comp_t g[9]);
		logic [IN_W-1:0] b;
		for (int i = 0; i < 3; i++) b[i*VEC_W +: VEC_W] = d[i];
		for (int i = 0; i < 9; i++) b[(3+i)*VEC_W +: VEC_W] = g[i];
		return b;
	endfunction

	// mostly components within one, moderate gradients in under half the beats, else raw noise
	function automatic logic [IN_W-1:0] random_beat();
		comp_t d[3], g[9];
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++)
			d[i] = (kind < 7) ? comp_t'($signed($urandom_range(0, 32'h8000_0000)) >>> 1)
				: comp_t'($urandom);
		for (int i = 0; i < 9; i++)
			g[i] = (kind < 4) ? comp_t'($signed($urandom) >>> $urandom_range(0, 24))
				: comp_t'($urandom);
		return pack(d, g);
	endfunction

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		comp_t d[3], g[9];
		comp_t ext[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh4000_0000, 32'sh0};
		// zero vector, and exactly half length: both give zero
		d = '{0, 0, 0};
		g = '{default: 32'sh7FFF_FFFF};
		send_beat(pack(d, g));
		d = '{32'sh2000_0000, 0, 0};
		send_beat(pack(d, g));
		// just over half length
		d = '{32'sh2000_0001, 0, 0};
		send_beat(pack(d, g));
		d = '{0, 32'shE000_0000, 1};
		send_beat(pack(d, g));
		// component and gradient extremes
		for (int k = 0; k < 4; k++) begin
			d = '{ext[k], ext[(k+1)%4], ext[(k+2)%4]};
			g = '{default: ext[(k+3)%4]};
			send_beat(pack(d, g));
			g = '{default: ext[k]};
			send_beat(pack(d, g));
		end
		d = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		g = '{default: 32'sh8000_0000};
		send_beat(pack(d, g));
		d = '{32'sh4000_0000, 0, 0};
		g = '{32'sh0100_0000, 32'sh0200_0000, 0, 0, 32'shFF00_0000, 0, 0, 0, 32'sh0001_0000};
		send_beat(pack(d, g));
	endtask

	task automatic test_config_sweep();
		// both modes, step extremes
		write_reg(CFG_FIRST_STEP, 32'd1);
		test_directed();
		write_reg(CFG_FIRST_STEP, 32'hFFFF_FFFE);   // upper bits ignored: bit 0 = 0
		write_reg(CFG_STEP_LENGTH, 32'hFFFF_FFFF);
		test_directed();
		write_reg(CFG_STEP_LENGTH, 32'd0);
		test_directed();
	endtask

	task automatic test_random(int count, int drain_at);
		for (int k = 0; k < count; k++) begin
			no_idle = (k % 150) < 30;
			if (k == drain_at) drain();
			send_beat(random_beat());
		end
		no_idle = 0;
	endtask

	task automatic test_random_settings();
		write_reg(CFG_STEP_LENGTH, $urandom);
		test_random(250, 120);
		write_reg(CFG_FIRST_STEP, 32'd1);
		test_random(150, -1);
		write_reg(CFG_FIRST_STEP, 32'd0);
		write_reg(CFG_STEP_LENGTH, $urandom_range(1, 32'h0000_FFFF));
		test_random(250, -1);
		write_reg(CFG_STEP_LENGTH, 32'hFFFF_FFFF);
		test_random(150, -1);
		write_reg(CFG_STEP_LENGTH, $urandom);
		test_random(250, -1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		errors = 0;
		no_idle = 0;
		stall_left = 0;
		only_normalize = 0;
		dt_raw = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_settings();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
